>>> rtl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    // Default number of cells in the queue chain.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Width of the occupancy field in a result.
    localparam int OCC_W = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // One queued job as held in a cell.
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [7:0]  id;
    } t_entry;

    // One request at the input.
    typedef struct packed {
        logic        command;
        logic [7:0]  job_id;
        logic [15:0] burst_length;
        logic [7:0]  job_priority;
    } t_request;

    // One result at the output.
    typedef struct packed {
        logic [7:0]       running_job;
        logic             job_finished;
        logic             insert_dropped;
        logic [OCC_W-1:0] queue_occupancy;
    } t_result;

    // Operation broadcast to the cells.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_DEC
    } t_cell_op;

    // Control bundle sent from the top level to every cell.
    typedef struct packed {
        t_cell_op op;
        t_entry   new_entry;
    } t_cell_ctrl;

endpackage

>>> rtl/pps_cell.sv
// One cell of the sorted scheduler chain: holds one job and its valid bit.
module pps_cell
    import pps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_prev_keep,
    input  t_entry     i_left_entry,
    input  logic       i_left_valid,
    input  t_entry     i_right_entry,
    input  logic       i_right_valid,
    output t_entry     o_entry,
    output logic       o_valid,
    output logic       o_keep
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    // A valid cell keeps its job in place when the new job ranks below or equal to it.
    assign o_keep  = r_valid && (r_entry.prio >= i_ctrl.new_entry.prio);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    // Next contents of the cell for each chain operation.
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_prev_keep) begin
                        n_entry = i_ctrl.new_entry;
                        n_valid = 1'b1;
                    end else begin
                        n_entry = i_left_entry;
                        n_valid = i_left_valid;
                    end
                end
            end
            CELL_POP: begin
                n_entry = i_right_entry;
                n_valid = i_right_valid;
            end
            CELL_DEC: begin
                n_entry.burst = r_entry.burst - 16'd1;
            end
            default: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
        endcase
    end

    // The valid bit is cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Job contents need no reset.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: a sorted chain of job cells with a request port.
//
// A request is taken at a clock edge where start is high and busy is low.
// busy is never raised, so one request can be taken every cycle.
// A request either inserts a job (id, burst, priority) or is a time tick.
// On a tick the job at the head of the chain runs for one unit; when its
// burst runs out it leaves and is reported finished. An idle tick reports
// job 0. Inserts with a zero burst are ignored; inserts into a full queue are
// dropped and flagged. Equal priorities are served in insertion order.
// Each request gives exactly one result, shown on o_result for one cycle with
// o_done high, in the cycle after the request is taken; one request can be
// taken per cycle. Every cell compares its priority with the new job at once
// and shifts by one place, so the whole chain updates at the same clock edge.
// The receiver cannot stall; it must take each result in its cycle.
// Synchronous reset empties the queue and drops any pending result strobe.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_request,
    output logic     o_done,
    output t_result  o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Chain wiring between neighbors.
    t_entry     w_entry [QUEUE_DEPTH];
    logic       w_valid [QUEUE_DEPTH];
    logic       w_keep  [QUEUE_DEPTH];
    t_cell_ctrl w_ctrl_head;
    t_cell_ctrl w_ctrl_body;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_result          r_result;
    t_result          n_result;

    logic w_is_tick;
    logic w_full;
    logic w_insert_ok;
    logic w_drop;
    logic w_tick_run;
    logic w_head_last;
    logic [CNT_W+OCC_W-1:0] w_occ_wide;

    assign busy = 1'b0;

    // Decode the request.
    assign w_is_tick   = (i_request.command == CMD_TICK);
    assign w_full      = (r_count == DEPTH_C);
    assign w_insert_ok = start && !w_is_tick && (i_request.burst_length != 16'd0) && !w_full;
    assign w_drop      = start && !w_is_tick && (i_request.burst_length != 16'd0) && w_full;
    assign w_tick_run  = start && w_is_tick && (r_count != '0);
    assign w_head_last = (w_entry[0].burst == 16'd1);

    // Operation sent along the chain; only the head cell decrements.
    always_comb begin
        w_ctrl_head.new_entry.prio  = i_request.job_priority;
        w_ctrl_head.new_entry.burst = i_request.burst_length;
        w_ctrl_head.new_entry.id    = i_request.job_id;
        w_ctrl_body.new_entry       = w_ctrl_head.new_entry;
        if (w_insert_ok) begin
            w_ctrl_head.op = CELL_INSERT;
            w_ctrl_body.op = CELL_INSERT;
        end else if (w_tick_run && w_head_last) begin
            w_ctrl_head.op = CELL_POP;
            w_ctrl_body.op = CELL_POP;
        end else if (w_tick_run) begin
            w_ctrl_head.op = CELL_DEC;
            w_ctrl_body.op = CELL_HOLD;
        end else begin
            w_ctrl_head.op = CELL_HOLD;
            w_ctrl_body.op = CELL_HOLD;
        end
    end

    // Occupancy after this request.
    always_comb begin
        n_count = r_count;
        if (w_insert_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_tick_run && w_head_last) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_occ_wide = {{OCC_W{1'b0}}, n_count};

    // Result for this request.
    always_comb begin
        n_result.running_job     = w_tick_run ? w_entry[0].id : 8'd0;
        n_result.job_finished    = w_tick_run && w_head_last;
        n_result.insert_dropped  = w_drop;
        n_result.queue_occupancy = w_occ_wide[OCC_W-1:0];
    end

    // The chain of cells, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   w_prev_keep;
        t_entry w_left_entry;
        logic   w_left_valid;
        t_entry w_right_entry;
        logic   w_right_valid;

        if (g == 0) begin : g_head
            assign w_prev_keep  = 1'b1;
            assign w_left_entry = '0;
            assign w_left_valid = 1'b0;
        end else begin : g_mid
            assign w_prev_keep  = w_keep[g-1];
            assign w_left_entry = w_entry[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right_entry = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        pps_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        ((g == 0) ? w_ctrl_head : w_ctrl_body),
            .i_prev_keep   (w_prev_keep),
            .i_left_entry  (w_left_entry),
            .i_left_valid  (w_left_valid),
            .i_right_entry (w_right_entry),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_keep        (w_keep[g])
        );
    end

    // Control state: occupancy and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= start;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> tb/sv/preemptive_priority_scheduler_tb.sv
// Self-checking testbench for the preemptive priority scheduler.
module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int PHASE_ITEMS  = 460;
    localparam int IDLE_LIMIT   = 500;
    localparam int MAX_REPORTS  = 10;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_done;
    t_result  o_result;

    // Scheduler image kept by the testbench, head of the queue first.
    t_entry   ready_jobs[$];
    t_result  pending_results[$];

    // Directed stimulus table; a known row carries its expected result.
    t_request directed_reqs[$];
    bit       directed_known[$];
    t_result  directed_results[$];

    // Sideband for the request on the port.
    bit       row_known;
    t_result  row_expected;

    int       burst_left;
    int       idle_cycles;
    int       mismatches;
    int       n_inserts;
    int       n_ticks;
    int       n_drops;
    int       n_finished;

    preemptive_priority_scheduler #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Runs one request against the scheduler image and returns its result.
    function automatic t_result schedule_step(t_request req);
        t_result res;
        t_entry  job;
        int      pos;
        res = '0;
        if (req.command == CMD_INSERT) begin
            if (req.burst_length != 16'd0) begin
                if (ready_jobs.size() >= DEPTH) begin
                    res.insert_dropped = 1'b1;
                end else begin
                    // Equal priorities queue behind the jobs already waiting.
                    pos = 0;
                    while (pos < ready_jobs.size() && ready_jobs[pos].prio >= req.job_priority)
                        pos++;
                    job.prio  = req.job_priority;
                    job.burst = req.burst_length;
                    job.id    = req.job_id;
                    ready_jobs.insert(pos, job);
                end
            end
        end else if (ready_jobs.size() > 0) begin
            // The head job runs one unit and leaves when its burst is used up.
            res.running_job = ready_jobs[0].id;
            ready_jobs[0].burst = ready_jobs[0].burst - 16'd1;
            if (ready_jobs[0].burst == 16'd0) begin
                res.job_finished = 1'b1;
                void'(ready_jobs.pop_front());
            end
        end
        res.queue_occupancy = OCC_W'(ready_jobs.size());
        return res;
    endfunction

    function automatic t_request mk_insert(logic [7:0] id, logic [15:0] burst, logic [7:0] prio);
        t_request req;
        req.command      = CMD_INSERT;
        req.job_id       = id;
        req.burst_length = burst;
        req.job_priority = prio;
        return req;
    endfunction

    function automatic t_request mk_tick();
        t_request req;
        req = '0;
        req.command = CMD_TICK;
        return req;
    endfunction

    function automatic t_result mk_result(logic [7:0] run, logic fin, logic drop, int occ);
        t_result res;
        res.running_job     = run;
        res.job_finished    = fin;
        res.insert_dropped  = drop;
        res.queue_occupancy = OCC_W'(occ);
        return res;
    endfunction

    task automatic add_row(t_request req, bit known, t_result res);
        directed_reqs.push_back(req);
        directed_known.push_back(known);
        directed_results.push_back(res);
    endtask

    // Random request; tick fields are left random since the block ignores them.
    function automatic t_request random_request(int tick_pct);
        t_request req;
        req.job_id       = 8'($urandom);
        req.burst_length = 16'($urandom);
        req.job_priority = 8'($urandom);
        if ($urandom_range(99, 0) < tick_pct) begin
            req.command = CMD_TICK;
        end else begin
            req.command = CMD_INSERT;
            // Mostly short bursts so jobs come and go; a few long ones and zeros.
            case ($urandom_range(127, 0))
                0:       req.burst_length = 16'($urandom_range(65535, 1));
                1, 2, 3,
                4, 5, 6: req.burst_length = 16'd0;
                default: req.burst_length = 16'($urandom_range(6, 1));
            endcase
            // Narrow priorities often, so that ties are common.
            if ($urandom_range(1, 0) == 0)
                req.job_priority = 8'($urandom_range(3, 0));
        end
        return req;
    endfunction

    // Presents one request from a falling edge and returns at the falling edge
    // after it has been taken. The sender may idle between bursts of requests.
    task automatic send_request(t_request req, bit known, t_result res, bit no_idle);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end
        burst_left--;
        if (!no_idle) begin
            repeat (gap) begin
                start = 1'b0;
                @(negedge i_clk);
            end
        end
        start        = 1'b1;
        i_request    = req;
        row_known    = known;
        row_expected = res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"Mismatch: expected job=%0d fin=%0d drop=%0d occ=%0d,",
                      " got job=%0d fin=%0d drop=%0d occ=%0d"},
                     want.running_job, want.job_finished, want.insert_dropped,
                     want.queue_occupancy, got.running_job, got.job_finished,
                     got.insert_dropped, got.queue_occupancy);
    endtask

    // Result checking, prediction of taken requests and the idle counter.
    always @(posedge i_clk) begin
        t_result want;
        bit      active;
        active = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                active = 1'b1;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: job=%0d fin=%0d drop=%0d occ=%0d",
                                 o_result.running_job, o_result.job_finished,
                                 o_result.insert_dropped, o_result.queue_occupancy);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.running_job !== want.running_job ||
                        o_result.job_finished !== want.job_finished ||
                        o_result.insert_dropped !== want.insert_dropped ||
                        o_result.queue_occupancy !== want.queue_occupancy)
                        report_mismatch(want, o_result);
                end
            end
            if (start && !busy) begin
                active = 1'b1;
                want = schedule_step(i_request);
                if (row_known)
                    want = row_expected;
                pending_results.push_back(want);
                if (i_request.command == CMD_TICK)
                    n_ticks++;
                else
                    n_inserts++;
                if (want.insert_dropped)
                    n_drops++;
                if (want.job_finished)
                    n_finished++;
            end
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
    end

    // Watchdog on stretches with no request taken and no result shown.
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, wind-down.
    initial begin
        int tick_pct[4];
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_request    = '0;
        row_known    = 1'b0;
        row_expected = '0;
        burst_left   = 0;
        idle_cycles  = 0;
        mismatches   = 0;
        n_inserts    = 0;
        n_ticks      = 0;
        n_drops      = 0;
        n_finished   = 0;
        tick_pct     = '{50, 25, 75, 45};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Idle tick, zero burst, extremes, ties, job id zero, full queue.
        add_row(mk_tick(), 1'b1, mk_result(8'd0, 1'b0, 1'b0, 0));
        add_row(mk_insert(8'd5, 16'd0, 8'd9), 1'b1, mk_result(8'd0, 1'b0, 1'b0, 0));
        add_row(mk_insert(8'd255, 16'd1, 8'd255), 1'b1, mk_result(8'd0, 1'b0, 1'b0, 1));
        add_row(mk_tick(), 1'b1, mk_result(8'd255, 1'b1, 1'b0, 0));
        add_row(mk_insert(8'd0, 16'd2, 8'd0), 1'b1, mk_result(8'd0, 1'b0, 1'b0, 1));
        add_row(mk_insert(8'd7, 16'd1, 8'd0), 1'b1, mk_result(8'd0, 1'b0, 1'b0, 2));
        add_row(mk_tick(), 1'b0, '0);
        add_row(mk_tick(), 1'b0, '0);
        add_row(mk_tick(), 1'b0, '0);
        add_row(mk_insert(8'd200, 16'hFFFF, 8'd128), 1'b0, '0);
        for (int k = 0; k < DEPTH - 1; k++)
            add_row(mk_insert(8'(10 + k), 16'(k + 1), 8'((k * 37) & 255)), 1'b0, '0);
        add_row(mk_insert(8'd99, 16'd4, 8'd200), 1'b1, mk_result(8'd0, 1'b0, 1'b1, DEPTH));
        add_row(mk_insert(8'd98, 16'd0, 8'd200), 1'b1, mk_result(8'd0, 1'b0, 1'b0, DEPTH));
        add_row(mk_tick(), 1'b0, '0);

        for (int k = 0; k < directed_reqs.size(); k++)
            send_request(directed_reqs[k], directed_known[k], directed_results[k], k[0]);

        // Random phases with different tick rates; each starts with the sender
        // held off until all results are in. The queue carries over between phases.
        for (int ph = 0; ph < 4; ph++) begin
            start = 1'b0;
            while (pending_results.size() != 0) @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request(tick_pct[ph]), 1'b0, '0, ph == 2);
        end

        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Summary: %0d inserts and %0d ticks taken; %0d jobs ran to completion,",
                 n_inserts, n_ticks, n_finished);
        $display("Summary: %0d inserts dropped on a full queue, %0d mismatches.",
                 n_drops, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
